@@ hdl/kcem_pkg.sv @@
`default_nettype none

package kcem_pkg;

  // Field widths
  localparam int unsigned KeyW      = 32;
  localparam int unsigned PosW      = 5;
  localparam int unsigned SlotIdxW  = 4;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned IndexSlots = 16;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam logic [ApbAddrW-3:0] RegKeyCount = 1'b0;

  // Input item codes
  localparam logic ActScan = 1'b0;
  localparam logic ActLoad = 1'b1;

  typedef struct packed {
    logic                action;
    logic [KeyW-1:0]     key_vector;
    logic [SlotIdxW-1:0] entry_index;
    logic [CodeW-1:0]    entry_scancode;
    logic [CodeW-1:0]    entry_keycode;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  scancode;
    logic [CodeW-1:0] keycode;
    logic             matched;
    logic             pressed;
    logic             sync;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

`default_nettype wire

@@ hdl/key_change_event_mapper.sv @@
`default_nettype none

// Key change event mapper. A scan transfer (action 0) is XORed with the
// previous key vector; the difference is walked one bit per cycle from bit 0
// upward in a shift register; each changed key has its position matched
// against the first key_count table slots at once and then waits in the emit
// state until the output register is free, so a scan stalls the input until
// its last result is registered. A scan with no change and a table load
// (action 1) emit nothing and do not stall the input.
// The output register lets the next transfer be taken while the last result
// still waits. key_count (byte address 0) sets how many slots from slot 0
// are searched; slots must be loaded before they are searched.
module key_change_event_mapper #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // item input
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  kcem_pkg::in_item_t       in_data_i,
  // result output
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output kcem_pkg::out_item_t            out_data_o,
  // configuration
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [kcem_pkg::ApbAddrW-1:0]  paddr,
  input  wire  [kcem_pkg::ApbDataW-1:0]  pwdata,
  output logic [kcem_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import kcem_pkg::*;

  // Slots reachable by a 4-bit slot index
  localparam int unsigned Slots = (TABLE_DEPTH < IndexSlots) ? TABLE_DEPTH : IndexSlots;

  state_e            state_q, state_d;
  logic [KeyW-1:0]   prev_q;
  logic [KeyW-1:0]   diff_q, diff_d;
  logic [KeyW-1:0]   keys_q, keys_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              any_q, any_d;
  logic [CountW-1:0] key_count_q;
  logic [CodeW-1:0]  scan_tbl_q [Slots];
  logic [CodeW-1:0]  key_tbl_q  [Slots];
  logic [Slots-1:0]  hits_q, hits_d;
  logic [Slots-1:0]  hit_first;
  logic [PosW-1:0]   pend_pos_q, pend_pos_d;
  logic              pend_pressed_q, pend_pressed_d;
  logic              pend_last_q, pend_last_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [CodeW-1:0]  hit_code;
  logic              in_fire, scan_fire, load_fire, out_free, emit_go, cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[ApbAddrW-1:2] == RegKeyCount)
                  ? {{(ApbDataW-CountW){1'b0}}, key_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_wr && paddr[ApbAddrW-1:2] == RegKeyCount) begin
      key_count_q <= pwdata[CountW-1:0];
    end
  end

  // Handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign scan_fire  = in_fire && in_data_i.action == ActScan;
  assign load_fire  = in_fire && in_data_i.action == ActLoad;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit_go    = (state_q == ST_EMIT) && out_free;

  // Write table slots; slots past the table are dropped
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Slots; i++) begin
      if (load_fire && {1'b0, in_data_i.entry_index} == (SlotIdxW+1)'(i)) begin
        scan_tbl_q[i] <= in_data_i.entry_scancode;
        key_tbl_q[i]  <= in_data_i.entry_keycode;
      end
    end
  end

  // Pick the keycode of the lowest matching slot
  assign hit_first = hits_q & (~hits_q + Slots'(1));
  always_comb begin
    hit_code = '0;
    for (int i = 0; i < Slots; i++) begin
      if (hit_first[i]) begin
        hit_code = hit_code | key_tbl_q[i];
      end
    end
  end

  // Walk the change vector and sequence the results
  always_comb begin
    state_d        = state_q;
    diff_d         = diff_q;
    keys_d         = keys_q;
    pos_d          = pos_q;
    any_d          = any_q;
    hits_d         = hits_q;
    pend_pos_d     = pend_pos_q;
    pend_pressed_d = pend_pressed_q;
    pend_last_d    = pend_last_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (scan_fire) begin
          diff_d  = in_data_i.key_vector ^ prev_q;
          keys_d  = in_data_i.key_vector;
          pos_d   = '0;
          any_d   = 1'b0;
          state_d = ((in_data_i.key_vector ^ prev_q) != '0) ? ST_WALK : ST_IDLE;
        end
      end
      ST_WALK: begin
        // advance one bit; on a change, match its position against the table
        if (diff_q[0]) begin
          for (int i = 0; i < Slots; i++) begin
            hits_d[i] = (CountW'(i) < key_count_q) &&
                        (scan_tbl_q[i] == {{(CodeW-PosW){1'b0}}, pos_q});
          end
          pend_pos_d     = pos_q;
          pend_pressed_d = keys_q[0];
          pend_last_d    = (diff_q[KeyW-1:1] == '0);
          state_d        = ST_EMIT;
        end
        diff_d = {1'b0, diff_q[KeyW-1:1]};
        keys_d = {1'b0, keys_q[KeyW-1:1]};
        pos_d  = pos_q + PosW'(1);
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          any_d          = any_q | (|hits_q);
          out_d.scancode = pend_pos_q;
          out_d.keycode  = hit_code;
          out_d.matched  = |hits_q;
          out_d.pressed  = pend_pressed_q;
          out_d.sync     = pend_last_q && (any_q || (|hits_q));
          out_d.last     = pend_last_q;
          out_valid_d    = 1'b1;
          state_d        = pend_last_q ? ST_IDLE : ST_WALK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (scan_fire) begin
        prev_q <= in_data_i.key_vector;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    diff_q         <= diff_d;
    keys_q         <= keys_d;
    pos_q          <= pos_d;
    any_q          <= any_d;
    hits_q         <= hits_d;
    pend_pos_q     <= pend_pos_d;
    pend_pressed_q <= pend_pressed_d;
    pend_last_q    <= pend_last_d;
    out_q          <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A walk always has a change left to find
  a_walk_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> diff_q != '0)
    else $error("walk state with empty change vector");

  // Sync only on the final result of a scan
  a_sync_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.sync || out_data_o.last))
    else $error("sync set on a result that is not last");

  // An emitted result carries the position that was matched
  a_emit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> out_valid_o && out_data_o.scancode == $past(pend_pos_q))
    else $error("emitted scancode differs from matched position");

  // The input stays stalled until the last result is registered
  a_stall_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && !pend_last_q) |=> state_q == ST_WALK)
    else $error("scan left before its last result");

endmodule

`default_nettype wire

@@ tb/tb_key_change_event_mapper.sv @@
`timescale 1ns / 100ps

module tb_key_change_event_mapper;
  import kcem_pkg::*;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainLimit   = 200000;
  localparam int unsigned ChunkItems   = 80;
  localparam logic [ApbAddrW-1:0] KeyCountAddr = {RegKeyCount, 2'b00};

  // Table contents loaded by the directed part: a duplicate scancode (3 in slots 3
  // and 8) and scancodes that can never match a key position (32, 0xFFFF).
  localparam logic [CodeW-1:0] SeedScancode [16] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7,
    16'd3, 16'd31, 16'd16, 16'd17, 16'd32, 16'hFFFF, 16'd30, 16'd29
  };
  localparam logic [CodeW-1:0] SeedKeycode [16] = '{
    16'hFFFF, 16'h0000, 16'h1234, 16'h0003, 16'h8001, 16'h5A5A, 16'hA5A5, 16'h00FF,
    16'hBEEF, 16'h7FFF, 16'h0101, 16'hC3C3, 16'h4242, 16'h9999, 16'h3C3C, 16'hF00D
  };

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    in_item_t           item;
    logic [ApbDataW-1:0] cfg_value;
    bit                 typed;
    int                 n_typed;
    out_item_t          typed_ev;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Predictor state
  logic [KeyW-1:0]   last_scan_keys;
  logic [CodeW-1:0]  slot_scancode [TableDepth];
  logic [CodeW-1:0]  slot_keycode  [TableDepth];
  logic [CountW-1:0] key_count_q;

  out_item_t   pending_events [$];
  dir_row_t    directed_rows  [$];
  int          mismatch_cnt  = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 73;
  logic        hold_active   = 1'b0;
  event        start_hold;

  key_change_event_mapper #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // Run limit
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Long receiver hold-off, counted here so the sender can keep pushing
  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // Receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic string fmt_event(input out_item_t ev);
    return $sformatf("sc=%0d kc=%h m=%b p=%b s=%b l=%b",
                     ev.scancode, ev.keycode, ev.matched, ev.pressed, ev.sync, ev.last);
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 10) begin
      $display("%0t: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // Walk the changed bits from bit 0 up and look each position up in the table;
  // the lowest matching slot wins. Loads only update the table.
  function automatic void map_key_changes(input in_item_t it, input bit push);
    logic [KeyW-1:0] diff;
    int unsigned     lim;
    logic            any_hit;
    out_item_t       ev;
    int              b;
    int              s;
    if (it.action == ActLoad) begin
      slot_scancode[it.entry_index] = it.entry_scancode;
      slot_keycode[it.entry_index]  = it.entry_keycode;
      return;
    end
    diff = it.key_vector ^ last_scan_keys;
    lim = key_count_q;
    if (lim > TableDepth) lim = TableDepth;
    if (lim > IndexSlots) lim = IndexSlots;
    any_hit = 1'b0;
    for (b = 0; b < KeyW; b++) begin
      if (diff[b]) begin
        ev = '0;
        ev.scancode = b[PosW-1:0];
        ev.pressed  = it.key_vector[b];
        for (s = 0; s < int'(lim); s++) begin
          if (!ev.matched && slot_scancode[s] == CodeW'(b)) begin
            ev.keycode = slot_keycode[s];
            ev.matched = 1'b1;
          end
        end
        any_hit = any_hit | ev.matched;
        if ((diff >> (b + 1)) == '0) begin
          ev.last = 1'b1;
          ev.sync = any_hit;
        end
        if (push) pending_events.push_back(ev);
      end
    end
    last_scan_keys = it.key_vector;
  endfunction

  // Offer one item, hold it until the transfer, and predict at the transfer
  task automatic send_item(input in_item_t it, input bit typed, input int n_typed,
                           input out_item_t typed_ev);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) begin
        map_key_changes(it, !typed);
        if (typed && n_typed == 1) pending_events.push_back(typed_ev);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic cfg_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done  = pready;
      rdata = prdata;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain the block, then write key_count and read it back
  task automatic apply_key_count(input logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] rd;
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_access(1'b1, KeyCountAddr, value, rd);
    key_count_q = value[CountW-1:0];
    cfg_access(1'b0, KeyCountAddr, '0, rd);
    if (rd !== {{(ApbDataW-CountW){1'b0}}, key_count_q}) begin
      flag_mismatch($sformatf("key_count readback: exp %h got %h",
                              {{(ApbDataW-CountW){1'b0}}, key_count_q}, rd));
    end
  endtask

  function automatic void add_row(input row_kind_e kind, input in_item_t it,
                                  input logic [ApbDataW-1:0] cfg, input bit typed,
                                  input int n_typed, input out_item_t ev);
    dir_row_t r;
    r.kind      = kind;
    r.item      = it;
    r.cfg_value = cfg;
    r.typed     = typed;
    r.n_typed   = n_typed;
    r.typed_ev  = ev;
    directed_rows.push_back(r);
  endfunction

  // Mostly well-formed key activity: few changed keys, repeats, full flips, table loads
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it.action         = ActScan;
    it.key_vector     = $urandom;
    it.entry_index    = SlotIdxW'($urandom_range(15));
    it.entry_scancode = CodeW'($urandom);
    it.entry_keycode  = CodeW'($urandom);
    pick = $urandom_range(99);
    if (pick < 18) begin
      it.action = ActLoad;
      if ($urandom_range(3) != 0) it.entry_scancode = CodeW'($urandom_range(31));
    end else if (pick < 28) begin
      it.key_vector = last_scan_keys;
    end else if (pick < 58) begin
      it.key_vector = last_scan_keys ^ (32'h1 << $urandom_range(31))
                      ^ (($urandom_range(1) ? 32'h1 : 32'h0) << $urandom_range(31));
    end else if (pick < 68) begin
      it.key_vector = ~last_scan_keys;
    end else if (pick < 80) begin
      it.key_vector = $urandom & $urandom & $urandom;
    end
    return it;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(negedge clk_i) begin
    out_item_t ev;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: %s", fmt_event(out_data_o)));
      end else begin
        ev = pending_events.pop_front();
        if (out_data_o.scancode !== ev.scancode || out_data_o.keycode !== ev.keycode ||
            out_data_o.matched  !== ev.matched  || out_data_o.pressed !== ev.pressed ||
            out_data_o.sync     !== ev.sync     || out_data_o.last    !== ev.last) begin
          flag_mismatch($sformatf("exp %s got %s", fmt_event(ev), fmt_event(out_data_o)));
        end
      end
    end
  end

  initial begin
    int               i;
    int               c;
    int               n;
    int               w;
    int unsigned      chunk_send [6];
    int unsigned      chunk_recv [6];
    logic [ApbDataW-1:0] chunk_count [6];
    out_item_t        none;

    none = '0;
    chunk_send  = '{19, 19, 73, 73, 0, 0};
    chunk_recv  = '{73, 73, 19, 19, 0, 0};
    chunk_count = '{32'd16, 32'hFFFF_FFE7, 32'd31, 32'd0, 32'd16, 32'd3};

    last_scan_keys = '0;
    key_count_q    = '0;
    for (i = 0; i < TableDepth; i++) begin
      slot_scancode[i] = '0;
      slot_keycode[i]  = '0;
    end

    // Directed stimulus, empty search range first
    add_row(ROW_ITEM, '{ActScan, 32'h0, 4'd0, 16'd0, 16'd0}, '0, 1'b1, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'h0000_0001, 4'd0, 16'd0, 16'd0}, '0, 1'b1, 1,
            '{5'd0, 16'h0, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(ROW_ITEM, '{ActScan, 32'h8000_0001, 4'd0, 16'd0, 16'd0}, '0, 1'b1, 1,
            '{5'd31, 16'h0, 1'b0, 1'b1, 1'b0, 1'b1});
    add_row(ROW_ITEM, '{ActScan, 32'h8000_0001, 4'd0, 16'd0, 16'd0}, '0, 1'b1, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'hFFFF_FFFF, 4'd0, 16'd0, 16'd0}, '0, 1'b0, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'h0, 4'd0, 16'd0, 16'd0}, '0, 1'b0, 0, none);
    for (i = 0; i < TableDepth; i++) begin
      add_row(ROW_ITEM, '{ActLoad, 32'h0, i[SlotIdxW-1:0], SeedScancode[i], SeedKeycode[i]},
              '0, 1'b1, 0, none);
    end
    add_row(ROW_CFG, '0, 32'd16, 1'b0, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'h0000_0008, 4'd0, 16'd0, 16'd0}, '0, 1'b0, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'hFFFF_FFFF, 4'd0, 16'd0, 16'd0}, '0, 1'b0, 0, none);
    add_row(ROW_ITEM, '{ActScan, 32'h8000_0000, 4'd0, 16'd0, 16'd0}, '0, 1'b0, 0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        apply_key_count(directed_rows[i].cfg_value);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed,
                  directed_rows[i].n_typed, directed_rows[i].typed_ev);
      end
    end

    // Random chunks; the fifth one starts with a long receiver hold-off
    for (c = 0; c < 6; c++) begin
      apply_key_count(chunk_count[c]);
      send_idle_pct <= chunk_send[c];
      recv_idle_pct <= chunk_recv[c];
      if (c == 4) -> start_hold;
      for (n = 0; n < ChunkItems; n++) begin
        send_item(random_item(), 1'b0, 0, none);
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    for (w = 0; w < DrainLimit && pending_events.size() != 0; w++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_events.size()));
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ key_change_event_mapper.f @@
hdl/kcem_pkg.sv
hdl/key_change_event_mapper.sv
tb/tb_key_change_event_mapper.sv
